// ===== rtl/thermal_jet_colormap_assert.svh =====
// ----------------------------------------------------------------------------
// Thermal jet colormap assertion macros
// Shorthand for the concurrent checks on the colormap ports.
// ----------------------------------------------------------------------------
`ifndef THERMAL_JET_COLORMAP_ASSERT_SVH
`define THERMAL_JET_COLORMAP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TJC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TJC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tjc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal jet colormap package
// Shared types and constants of the colormap pipeline.
// ----------------------------------------------------------------------------
package tjc_pkg;

	localparam int TEMP_W  = 14;
	localparam int SPAN_W  = 14;
	localparam int CHAN_W  = 8;
	localparam int REG_IDX_W = 1;

	localparam logic [SPAN_W-1:0] MIN_SPAN = SPAN_W'(240);
	localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST = TEMP_W'(0);
	localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST = TEMP_W'(240);

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_MIN_TEMP = 1'b0;
	localparam reg_idx_t REG_MAX_TEMP = 1'b1;

	typedef struct packed {
		logic valid;
		logic clamp_lo;
		logic clamp_hi;
	} ctl_t;

endpackage

// ===== rtl/tjc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal jet colormap front end
// Forms the offset from the minimum and the span, then the clamp flags.
// ----------------------------------------------------------------------------
module tjc_front import tjc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic signed [TEMP_W-1:0] min_temp,
	input  logic signed [TEMP_W-1:0] max_temp,
	input  logic                     sample_valid,
	input  logic signed [TEMP_W-1:0] temperature,
	output ctl_t                     ctl_o,
	output logic [SPAN_W-1:0]        rem_o,
	output logic [SPAN_W-1:0]        span_o
);

	logic signed [TEMP_W:0] diff_c;
	logic signed [TEMP_W:0] span_raw_c;
	logic [SPAN_W-1:0]      span_c;

	logic                   valid_s1;
	logic signed [TEMP_W:0] diff_s1;
	logic [SPAN_W-1:0]      span_s1;

	ctl_t                   ctl_s2;
	logic [SPAN_W-1:0]      rem_s2;
	logic [SPAN_W-1:0]      span_s2;

	logic                   lo_c;
	logic                   hi_c;

	assign diff_c     = (TEMP_W+1)'(temperature) - (TEMP_W+1)'(min_temp);
	assign span_raw_c = (TEMP_W+1)'(max_temp) - (TEMP_W+1)'(min_temp);
	assign span_c     = (span_raw_c < $signed({1'b0, MIN_SPAN})) ? MIN_SPAN :
		span_raw_c[SPAN_W-1:0];

	assign lo_c = (diff_s1 <= $signed((TEMP_W+1)'(0)));
	assign hi_c = !lo_c && (diff_s1[SPAN_W-1:0] >= span_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctl_s2   <= '0;
		end else if (adv) begin
			valid_s1        <= sample_valid;
			ctl_s2.valid    <= valid_s1;
			ctl_s2.clamp_lo <= lo_c;
			ctl_s2.clamp_hi <= hi_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s1 <= diff_c;
			span_s1 <= span_c;
			rem_s2  <= (lo_c || hi_c) ? '0 : diff_s1[SPAN_W-1:0];
			span_s2 <= span_s1;
		end
	end

	assign ctl_o  = ctl_s2;
	assign rem_o  = rem_s2;
	assign span_o = span_s2;

endmodule

// ===== rtl/tjc_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal jet colormap divider stage
// One restoring division step: yields one quotient bit per item.
// ----------------------------------------------------------------------------
module tjc_div_stage import tjc_pkg::*; #(
	parameter int NORM_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  ctl_t                 ctl_i,
	input  logic [SPAN_W-1:0]    rem_i,
	input  logic [SPAN_W-1:0]    span_i,
	input  logic [NORM_BITS-1:0] quo_i,
	output ctl_t                 ctl_o,
	output logic [SPAN_W-1:0]    rem_o,
	output logic [SPAN_W-1:0]    span_o,
	output logic [NORM_BITS-1:0] quo_o
);

	logic [SPAN_W:0]        shifted_c;
	logic                   take_c;
	logic [SPAN_W:0]        next_c;

	ctl_t                   ctl_s1;
	logic [SPAN_W-1:0]      rem_s1;
	logic [SPAN_W-1:0]      span_s1;
	logic [NORM_BITS-1:0]   quo_s1;

	assign shifted_c = {rem_i, 1'b0};
	assign take_c    = (shifted_c >= {1'b0, span_i});
	assign next_c    = take_c ? (shifted_c - {1'b0, span_i}) : shifted_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s1  <= next_c[SPAN_W-1:0];
			span_s1 <= span_i;
			quo_s1  <= {quo_i[NORM_BITS-2:0], take_c};
		end
	end

	assign ctl_o  = ctl_s1;
	assign rem_o  = rem_s1;
	assign span_o = span_s1;
	assign quo_o  = quo_s1;

endmodule

// ===== rtl/tjc_color.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal jet colormap color stage
// Applies the clamp, evaluates the jet curve and scales each channel to 8 bits.
// ----------------------------------------------------------------------------
module tjc_color import tjc_pkg::*; #(
	parameter int NORM_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  ctl_t                 ctl_i,
	input  logic [NORM_BITS-1:0] quo_i,
	output logic                 pixel_valid,
	output logic [CHAN_W-1:0]    red,
	output logic [CHAN_W-1:0]    green,
	output logic [CHAN_W-1:0]    blue
);

	localparam int PW  = NORM_BITS + 1;
	localparam int ONE = 1 << NORM_BITS;
	localparam int E   = ONE / 8;
	localparam logic [PW-1:0] ONE_L = PW'(ONE);
	localparam logic [PW-1:0] E1 = PW'(E);
	localparam logic [PW-1:0] E3 = PW'(3 * E);
	localparam logic [PW-1:0] E5 = PW'(5 * E);
	localparam logic [PW-1:0] E7 = PW'(7 * E);
	localparam logic [PW-1:0] E9 = PW'(9 * E);
	localparam int XW = PW + 9;

	logic [PW-1:0]   p_c;
	logic [PW-1:0]   r_c;
	logic [PW-1:0]   g_c;
	logic [PW-1:0]   b_c;
	logic [XW-1:0]   r_x;
	logic [XW-1:0]   g_x;
	logic [XW-1:0]   b_x;

	logic            valid_s1;
	logic [PW-1:0]   r_s1;
	logic [PW-1:0]   g_s1;
	logic [PW-1:0]   b_s1;

	logic            valid_s2;
	logic [CHAN_W-1:0] red_s2;
	logic [CHAN_W-1:0] green_s2;
	logic [CHAN_W-1:0] blue_s2;

	always_comb begin
		if (ctl_i.clamp_lo) begin
			p_c = '0;
		end else if (ctl_i.clamp_hi) begin
			p_c = ONE_L;
		end else begin
			p_c = {1'b0, quo_i};
		end

		if (p_c inside {[E3:E5-1]}) begin
			r_c = PW'((p_c - E3) << 2);
		end else if (p_c inside {[E5:E7-1]}) begin
			r_c = ONE_L;
		end else if (p_c >= E7) begin
			r_c = PW'((E9 - p_c) << 2);
		end else begin
			r_c = '0;
		end

		if (p_c inside {[E1:E3-1]}) begin
			g_c = PW'((p_c - E1) << 2);
		end else if (p_c inside {[E3:E5-1]}) begin
			g_c = ONE_L;
		end else if (p_c inside {[E5:E7-1]}) begin
			g_c = PW'((E7 - p_c) << 2);
		end else begin
			g_c = '0;
		end

		if (p_c < E1) begin
			b_c = PW'((p_c + E1) << 2);
		end else if (p_c < E3) begin
			b_c = ONE_L;
		end else if (p_c < E5) begin
			b_c = PW'((E5 - p_c) << 2);
		end else begin
			b_c = '0;
		end
	end

	// Multiply by 511 as a shift and subtract.
	assign r_x = {r_s1, 9'b0} - {9'b0, r_s1};
	assign g_x = {g_s1, 9'b0} - {9'b0, g_s1};
	assign b_x = {b_s1, 9'b0} - {9'b0, b_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= ctl_i.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1     <= r_c;
			g_s1     <= g_c;
			b_s1     <= b_c;
			red_s2   <= r_x[NORM_BITS+8:NORM_BITS+1];
			green_s2 <= g_x[NORM_BITS+8:NORM_BITS+1];
			blue_s2  <= b_x[NORM_BITS+8:NORM_BITS+1];
		end
	end

	assign pixel_valid = valid_s2;
	assign red         = red_s2;
	assign green       = green_s2;
	assign blue        = blue_s2;

endmodule

// ===== rtl/thermal_jet_colormap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal jet colormap
// Maps a temperature sample to an RGB color on the jet scale.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle unless stalled. Two front stages
// form the offset, span and clamp flags, NORM_BITS divider stages produce one
// quotient bit each, and two color stages evaluate the curve and scale it. A
// stall on the pixel side freezes the whole pipeline while a result waits, so
// the sample side is stalled only when the output holds an item that is not
// taken. Configuration writes are always ready and must be issued while the
// pipeline is empty.
module thermal_jet_colormap import tjc_pkg::*; #(
	parameter int NORM_BITS = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  reg_idx_t                 cfg_index,
	input  logic [TEMP_W-1:0]        cfg_data,
	input  logic                     sample_valid,
	output logic                     sample_stall,
	input  logic signed [TEMP_W-1:0] temperature,
	output logic                     pixel_valid,
	input  logic                     pixel_stall,
	output logic [CHAN_W-1:0]        red,
	output logic [CHAN_W-1:0]        green,
	output logic [CHAN_W-1:0]        blue
);

	logic signed [TEMP_W-1:0] min_temp_q;
	logic signed [TEMP_W-1:0] max_temp_q;
	logic                     adv;

	ctl_t                 ctl_c  [0:NORM_BITS];
	logic [SPAN_W-1:0]    rem_c  [0:NORM_BITS];
	logic [SPAN_W-1:0]    span_c [0:NORM_BITS];
	logic [NORM_BITS-1:0] quo_c  [0:NORM_BITS];

	assign cfg_ready    = 1'b1;
	assign adv          = !(pixel_valid && pixel_stall);
	assign sample_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_temp_q <= MIN_TEMP_RST;
			max_temp_q <= MAX_TEMP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_TEMP: min_temp_q <= cfg_data;
				REG_MAX_TEMP: max_temp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tjc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.min_temp     (min_temp_q),
		.max_temp     (max_temp_q),
		.sample_valid (sample_valid),
		.temperature  (temperature),
		.ctl_o        (ctl_c[0]),
		.rem_o        (rem_c[0]),
		.span_o       (span_c[0])
	);

	assign quo_c[0] = '0;

	for (genvar i = 0; i < NORM_BITS; i++) begin : g_div
		tjc_div_stage #(
			.NORM_BITS (NORM_BITS)
		) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.ctl_i  (ctl_c[i]),
			.rem_i  (rem_c[i]),
			.span_i (span_c[i]),
			.quo_i  (quo_c[i]),
			.ctl_o  (ctl_c[i+1]),
			.rem_o  (rem_c[i+1]),
			.span_o (span_c[i+1]),
			.quo_o  (quo_c[i+1])
		);
	end

	tjc_color #(
		.NORM_BITS (NORM_BITS)
	) u_color (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.ctl_i       (ctl_c[NORM_BITS]),
		.quo_i       (quo_c[NORM_BITS]),
		.pixel_valid (pixel_valid),
		.red         (red),
		.green       (green),
		.blue        (blue)
	);

endmodule

// ===== rtl/tjc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal jet colormap checker
// Port-level checks on the colormap, bound to the top level.
// ----------------------------------------------------------------------------
`include "thermal_jet_colormap_assert.svh"

module tjc_checker import tjc_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     sample_stall,
	input logic                     pixel_valid,
	input logic                     pixel_stall,
	input logic [CHAN_W-1:0]        red,
	input logic [CHAN_W-1:0]        green,
	input logic [CHAN_W-1:0]        blue
);

	logic                  out_wait;
	logic                  rb_lit;
	logic [3*CHAN_W-1:0]   rgb;

	assign out_wait = pixel_valid && pixel_stall;
	assign rb_lit   = pixel_valid && (red != '0) && (blue != '0);
	assign rgb      = {red, green, blue};

	`TJC_ASSERT_NEXT(a_hold_valid, out_wait, pixel_valid, "pixel item dropped while stalled")
	`TJC_ASSERT_NEXT(a_hold_data, out_wait, $stable(rgb), "pixel item changed while stalled")
	`TJC_ASSERT_SAME(a_stall_cause, sample_stall, out_wait, "sample stalled without a waiting item")
	`TJC_ASSERT_SAME(a_jet_mid, rb_lit, green == 8'd255, "red and blue lit without full green")

endmodule

bind thermal_jet_colormap tjc_checker u_tjc_checker (.*);
